// File: design/crcdf_pkg.sv
// Shared definitions for the CRC-8 packet deframer: sync bytes, CRC polynomial,
// result field layout and the per-byte CRC-8 update function.
// No dependencies.
package crcdf_pkg;

    localparam logic [7:0]  SYNC_FIRST      = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND     = 8'h55;
    localparam logic [7:0]  CRC_POLY        = 8'h07;
    localparam logic [7:0]  CRC_TOPBIT      = 8'h80;
    localparam logic [15:0] MAX_LEN_RESET   = 16'd144;

    localparam int          M_TDATA_W       = 56;

    // Result kinds carried on m_tuser
    localparam logic        KIND_PAYLOAD    = 1'b0;
    localparam logic        KIND_FRAME_END  = 1'b1;

    // m_tdata bit positions
    localparam int          DATA_LSB        = 0;
    localparam int          INDEX_LSB       = 8;
    localparam int          TYPE_LSB        = 24;
    localparam int          LEN_LSB         = 32;
    localparam int          CRC_OK_BIT      = 48;

    // CRC-8, MSB first, no reflection, no final xor
    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOPBIT) != 8'd0) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: design/crc8_packet_deframer.sv
// Sync-word / length / CRC-8 packet deframer, top level.
// Depends on crcdf_pkg.
//
// Usage:
//   s_ channel: one received link byte per transaction on s_tdata.
//   m_ channel: one result per payload byte (m_tuser = 0) and one per frame
//     end (m_tuser = 1, CRC byte checked, crc_ok in m_tdata).
//   Frame: 0xAA 0x55, type, length high, length low, payload, CRC-8.
//   cfg_we/cfg_wdata set the largest accepted payload length (reset 144);
//   write it only while the block is idle.
// Timing:
//   A byte is taken into an input register, decoded by the frame state
//   machine and any result it gives lands in the output register, which
//   drives m_tvalid. One byte per cycle is sustained while m_tready stays
//   high; the combinational CRC-8 update and state decode set this.
// Reset: aresetn (synchronous, active low) empties both registers and
//   returns the deframer to hunting for the sync word.
// Stall: while m_tready is low a held result stays stable; the input
//   register still takes one more byte, then s_tready drops.
module crc8_packet_deframer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] data_byte, [23:8] byte_index, [31:24] frame_type,
    // [47:32] payload_len, [48] crc_ok, [55:49] zero
    output logic [crcdf_pkg::M_TDATA_W-1:0] m_tdata,
    output logic        m_tuser     // [0] event_kind
);

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_TYPE,
        PH_LENHI,
        PH_LENLO,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] max_len_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    logic        m_tvalid_reg;
    logic [crcdf_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic        m_tuser_reg;

    logic        proc_en;
    logic [7:0]  crc_upd;
    logic [15:0] len_full;
    logic [15:0] count_inc;

    logic        res_valid;
    logic        res_kind;
    logic [crcdf_pkg::M_TDATA_W-1:0] res_data;

    assign proc_en  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc_en;

    assign crc_upd   = crcdf_pkg::crc8_update(crc_reg, in_byte_reg);
    assign len_full  = {len_reg[15:8], in_byte_reg};
    assign count_inc = count_reg + 16'd1;

    always_comb begin
        phase_next = phase_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        res_valid  = 1'b0;
        res_kind   = crcdf_pkg::KIND_PAYLOAD;
        res_data   = '0;
        if (proc_en) begin
            case (phase_reg)
                PH_HUNT1: begin
                    if (in_byte_reg == crcdf_pkg::SYNC_FIRST) begin
                        crc_next   = crc_upd;
                        phase_next = PH_HUNT2;
                    end
                end
                PH_HUNT2: begin
                    if (in_byte_reg == crcdf_pkg::SYNC_SECOND) begin
                        crc_next   = crc_upd;
                        phase_next = PH_TYPE;
                    end else begin
                        // not rechecked as a first sync byte
                        phase_next = PH_HUNT1;
                        count_next = '0;
                        crc_next   = '0;
                    end
                end
                PH_TYPE: begin
                    type_next  = in_byte_reg;
                    crc_next   = crc_upd;
                    phase_next = PH_LENHI;
                end
                PH_LENHI: begin
                    len_next   = {in_byte_reg, 8'd0};
                    crc_next   = crc_upd;
                    phase_next = PH_LENLO;
                end
                PH_LENLO: begin
                    len_next   = len_full;
                    crc_next   = crc_upd;
                    count_next = '0;
                    if (len_full == 16'd0) begin
                        phase_next = PH_CHECK;
                    end else if (len_full > max_len_reg) begin
                        // oversize frame dropped without a result
                        phase_next = PH_HUNT1;
                        crc_next   = '0;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    res_valid = 1'b1;
                    res_kind  = crcdf_pkg::KIND_PAYLOAD;
                    res_data[crcdf_pkg::DATA_LSB +: 8]   = in_byte_reg;
                    res_data[crcdf_pkg::INDEX_LSB +: 16] = count_reg;
                    res_data[crcdf_pkg::TYPE_LSB +: 8]   = type_reg;
                    res_data[crcdf_pkg::LEN_LSB +: 16]   = len_reg;
                    crc_next   = crc_upd;
                    count_next = count_inc;
                    if (count_inc == len_reg) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    res_valid = 1'b1;
                    res_kind  = crcdf_pkg::KIND_FRAME_END;
                    res_data[crcdf_pkg::TYPE_LSB +: 8]  = type_reg;
                    res_data[crcdf_pkg::LEN_LSB +: 16]  = len_reg;
                    res_data[crcdf_pkg::CRC_OK_BIT]     = (in_byte_reg == crc_reg);
                    phase_next = PH_HUNT1;
                    count_next = '0;
                    crc_next   = '0;
                end
                default: begin
                    phase_next = PH_HUNT1;
                    count_next = '0;
                    crc_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT1;
            type_reg     <= '0;
            len_reg      <= '0;
            count_reg    <= '0;
            crc_reg      <= '0;
            max_len_reg  <= crcdf_pkg::MAX_LEN_RESET;
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
            if (cfg_we) begin
                max_len_reg <= cfg_wdata;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (proc_en) begin
                m_tvalid_reg <= res_valid;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        if (proc_en) begin
            m_tdata_reg <= res_data;
            m_tuser_reg <= res_kind;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: design/crcdf_checker.sv
// Port-level checks for crc8_packet_deframer, attached by bind.
// Depends on crcdf_pkg.
module crcdf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [crcdf_pkg::M_TDATA_W-1:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_payload_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == crcdf_pkg::KIND_PAYLOAD) |->
            !m_tdata[crcdf_pkg::CRC_OK_BIT] &&
            (m_tdata[crcdf_pkg::INDEX_LSB +: 16] < m_tdata[crcdf_pkg::LEN_LSB +: 16]))
        else $error("payload transaction with bad index or crc flag");

    a_end_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == crcdf_pkg::KIND_FRAME_END) |->
            (m_tdata[crcdf_pkg::DATA_LSB +: 8] == 8'd0) &&
            (m_tdata[crcdf_pkg::INDEX_LSB +: 16] == 16'd0))
        else $error("frame end transaction carries payload fields");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[crcdf_pkg::M_TDATA_W-1:crcdf_pkg::CRC_OK_BIT+1] == '0))
        else $error("nonzero pad bits in result");

endmodule

bind crc8_packet_deframer crcdf_checker u_crcdf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/crc8_packet_deframer_tb.sv
// Self-checking testbench for crc8_packet_deframer: a byte-level frame predictor
// checks every payload and frame-end transaction under random stalls on both sides.
// Depends on crcdf_pkg and the crc8_packet_deframer RTL.
module crc8_packet_deframer_tb;

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        READ_TYPE,
        READ_LEN_HI,
        READ_LEN_LO,
        READ_PAYLOAD,
        READ_CRC
    } scan_phase_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [15:0] index;
        logic [7:0]  ftype;
        logic [15:0] len;
        logic        ok;
    } deframe_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [crcdf_pkg::M_TDATA_W-1:0] m_tdata;
    logic        m_tuser;

    // link bytes waiting to be offered, and results still owed by the block
    logic [7:0]      link_bytes[$];
    deframe_result_t pending_results[$];

    // frame predictor state
    scan_phase_t scan_phase   = HUNT_FIRST;
    logic [7:0]  scan_crc     = 8'd0;
    logic [7:0]  frame_type   = 8'd0;
    logic [15:0] frame_len    = 16'd0;
    logic [15:0] payload_pos  = 16'd0;
    logic [15:0] max_len      = crcdf_pkg::MAX_LEN_RESET;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_offer    = 1'b0;
    bit          stall_wanted  = 1'b0;
    bit          stall_done    = 1'b0;
    int unsigned stall_left    = 0;

    logic [7:0]  build_crc      = 8'd0;
    int unsigned error_count    = 0;
    int unsigned bytes_taken    = 0;
    int unsigned payload_seen   = 0;
    int unsigned frames_seen    = 0;
    int unsigned frames_good    = 0;
    int unsigned settings_used  = 1;
    deframe_result_t want;

    crc8_packet_deframer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // bit-serial CRC-8, MSB first
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ b[i];
            r = {r[6:0], 1'b0} ^ (fb ? crcdf_pkg::CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    task automatic restart_hunt();
        scan_phase  = HUNT_FIRST;
        payload_pos = 16'd0;
        scan_crc    = 8'd0;
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        deframe_result_t r;
        r = '0;
        bytes_taken++;
        case (scan_phase)
            HUNT_FIRST: begin
                if (b == crcdf_pkg::SYNC_FIRST) begin
                    scan_crc   = crc8_next(8'h00, b);
                    scan_phase = HUNT_SECOND;
                end
            end
            HUNT_SECOND: begin
                // a wrong byte here is not retried as a first sync byte
                if (b == crcdf_pkg::SYNC_SECOND) begin
                    scan_crc   = crc8_next(scan_crc, b);
                    scan_phase = READ_TYPE;
                end else begin
                    restart_hunt();
                end
            end
            READ_TYPE: begin
                frame_type = b;
                scan_crc   = crc8_next(scan_crc, b);
                scan_phase = READ_LEN_HI;
            end
            READ_LEN_HI: begin
                frame_len  = {b, 8'h00};
                scan_crc   = crc8_next(scan_crc, b);
                scan_phase = READ_LEN_LO;
            end
            READ_LEN_LO: begin
                frame_len   = {frame_len[15:8], b};
                scan_crc    = crc8_next(scan_crc, b);
                payload_pos = 16'd0;
                if (frame_len == 16'd0) begin
                    scan_phase = READ_CRC;
                end else if (frame_len > max_len) begin
                    restart_hunt();     // oversize: dropped, type and length kept
                end else begin
                    scan_phase = READ_PAYLOAD;
                end
            end
            READ_PAYLOAD: begin
                r.kind  = crcdf_pkg::KIND_PAYLOAD;
                r.data  = b;
                r.index = payload_pos;
                r.ftype = frame_type;
                r.len   = frame_len;
                pending_results.push_back(r);
                scan_crc    = crc8_next(scan_crc, b);
                payload_pos = payload_pos + 16'd1;
                if (payload_pos == frame_len) begin
                    scan_phase = READ_CRC;
                end
            end
            READ_CRC: begin
                r.kind  = crcdf_pkg::KIND_FRAME_END;
                r.ftype = frame_type;
                r.len   = frame_len;
                r.ok    = (b == scan_crc);
                pending_results.push_back(r);
                restart_hunt();
            end
            default: begin
                restart_hunt();
            end
        endcase
    endtask

    // sender: hold an offered byte until it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            hold_offer = s_tvalid && !s_tready;
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata);
                void'(link_bytes.pop_front());
            end
            if (!hold_offer) begin
                if (link_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= link_bytes[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (stall_wanted && !stall_done) begin
            stall_done = 1'b1;
            stall_left = 300;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected: tuser=%0b tdata=0x%0h",
                       m_tuser, m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("event_kind",  16'(want.kind),  16'(m_tuser));
                check_field("data_byte",   16'(want.data),
                            16'(m_tdata[crcdf_pkg::DATA_LSB +: 8]));
                check_field("byte_index",  want.index, m_tdata[crcdf_pkg::INDEX_LSB +: 16]);
                check_field("frame_type",  16'(want.ftype),
                            16'(m_tdata[crcdf_pkg::TYPE_LSB +: 8]));
                check_field("payload_len", want.len,   m_tdata[crcdf_pkg::LEN_LSB +: 16]);
                check_field("crc_ok",      16'(want.ok),
                            16'(m_tdata[crcdf_pkg::CRC_OK_BIT]));
                check_field("tdata_pad",   16'd0,
                            16'(m_tdata[crcdf_pkg::M_TDATA_W-1:crcdf_pkg::CRC_OK_BIT+1]));
                if (want.kind == crcdf_pkg::KIND_FRAME_END) begin
                    frames_seen++;
                    if (want.ok) frames_good++;
                end else begin
                    payload_seen++;
                end
            end
        end
    end

    task automatic push_link_byte(input logic [7:0] b);
        link_bytes.push_back(b);
        build_crc = crc8_next(build_crc, b);
    endtask

    // header, then payload and CRC unless the length will be dropped
    task automatic queue_frame(input logic [7:0] ftype, input logic [15:0] len,
                               input bit spoil_crc);
        build_crc = 8'd0;
        push_link_byte(crcdf_pkg::SYNC_FIRST);
        push_link_byte(crcdf_pkg::SYNC_SECOND);
        push_link_byte(ftype);
        push_link_byte(len[15:8]);
        push_link_byte(len[7:0]);
        if (len <= max_len) begin
            for (int i = 0; i < len; i++) begin
                push_link_byte(8'($urandom_range(255)));
            end
            link_bytes.push_back(spoil_crc ? build_crc ^ 8'($urandom_range(255, 1))
                                           : build_crc);
        end
    endtask

    task automatic queue_link_traffic(input int unsigned n_items);
        int unsigned added;
        int unsigned start;
        int unsigned pick;
        int unsigned cap;
        int unsigned len;
        logic [7:0]  bad_second;
        added = 0;
        while (added < n_items) begin
            pick  = $urandom_range(99);
            start = link_bytes.size();
            if (pick < 72) begin
                cap = (max_len < 12) ? 32'(max_len) : 12;
                len = $urandom_range(cap, 0);
                if ($urandom_range(29) == 0 && max_len <= 300) len = 32'(max_len);
                queue_frame(8'($urandom_range(255)), 16'(len), $urandom_range(5) == 0);
                added += link_bytes.size() - start;
            end else if (pick < 80) begin
                link_bytes.push_back(crcdf_pkg::SYNC_FIRST);
                do begin
                    bad_second = 8'($urandom_range(255));
                end while (bad_second == crcdf_pkg::SYNC_SECOND);
                link_bytes.push_back(bad_second);
                added += 2;
            end else if (pick < 88) begin
                if (max_len != 16'hFFFF) begin
                    len = ($urandom_range(1) != 0) ? 32'(max_len) + 1
                                                   : $urandom_range(65535, 32'(max_len) + 1);
                    queue_frame(8'($urandom_range(255)), 16'(len), 1'b0);
                    added += link_bytes.size() - start;
                end
            end else begin
                // line noise, rarely a stray first sync byte
                repeat ($urandom_range(3, 1)) begin
                    link_bytes.push_back(($urandom_range(7) == 0) ? crcdf_pkg::SYNC_FIRST
                                                                  : 8'($urandom_range(255)));
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (link_bytes.size() != 0 || s_tvalid || pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic set_max_len(input logic [15:0] v);
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        max_len = v;
        settings_used++;
    endtask

    initial begin
        send_idle_pct = 34;
        recv_idle_pct = 88;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: noise extremes, bad second sync, zero length, bad CRC, oversize
        link_bytes.push_back(8'h00);
        link_bytes.push_back(8'hFF);
        link_bytes.push_back(crcdf_pkg::SYNC_FIRST);
        link_bytes.push_back(8'h00);
        link_bytes.push_back(crcdf_pkg::SYNC_FIRST);
        link_bytes.push_back(crcdf_pkg::SYNC_FIRST);
        link_bytes.push_back(crcdf_pkg::SYNC_SECOND);
        queue_frame(8'h07, 16'd0, 1'b0);
        queue_frame(8'hFF, 16'd2, 1'b1);
        queue_frame(8'h01, crcdf_pkg::MAX_LEN_RESET + 16'd1, 1'b0);
        wait_drained();

        queue_link_traffic(250);
        stall_wanted = 1'b1;
        set_max_len(16'd0);
        queue_link_traffic(60);

        send_idle_pct = 88;
        recv_idle_pct = 34;
        set_max_len(16'hFFFF);
        queue_link_traffic(200);
        set_max_len(16'd1);
        queue_link_traffic(80);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_max_len(16'($urandom_range(300, 2)));
        queue_link_traffic(150);
        set_max_len(crcdf_pkg::MAX_LEN_RESET);
        queue_link_traffic(100);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
        end
        $display("Run covered %0d link bytes, %0d payload transactions, %0d frame ends",
                 bytes_taken, payload_seen, frames_seen);
        $display("(%0d with a matching CRC) over %0d length limits, 0 and 65535 among them",
                 frames_good, settings_used);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: crc8_packet_deframer.f
design/crcdf_pkg.sv
design/crc8_packet_deframer.sv
design/crcdf_checker.sv
tb/crc8_packet_deframer_tb.sv
